// ===== hw/rtl/sls_pkg.sv =====
// Shared types and constants for the string literal scanner.
`timescale 1ns / 1ps
`default_nettype none

package sls_pkg;

   localparam int unsigned DEPTH_LIMIT = 255;
   localparam int unsigned LEVEL_W = $clog2(DEPTH_LIMIT + 1);

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef logic [LEVEL_W-1:0] level_type;

   typedef enum logic [1:0] {
      ESC_NONE  = 2'd0,
      ESC_SLASH = 2'd1,
      ESC_HEX1  = 2'd2,
      ESC_HEX2  = 2'd3
   } esc_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_ESC   = 3'd1,
      ERR_BAD_HEX   = 3'd2,
      ERR_HEX_SHORT = 3'd3,
      ERR_UNTERM    = 3'd4,
      ERR_DEPTH     = 3'd5
   } err_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       at_end;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      err_type    err_code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      level_type  brace_level;
      level_type  nested_level;
      esc_type    escape_phase;
      logic [3:0] hex_high;
      logic       dollar_held;
   } scan_state_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } step_result_type;

   localparam scan_state_type SCAN_IDLE = '{
      brace_level:  '0,
      nested_level: '0,
      escape_phase: ESC_NONE,
      hex_high:     4'd0,
      dollar_held:  1'b0
   };

endpackage

`default_nettype wire

// ===== hw/rtl/sls_step.sv =====
// Combinational decode of one source byte against the scanner state.
`timescale 1ns / 1ps
`default_nettype none

module sls_step (
   input  sls_pkg::scan_state_type  state_cur,
   input  sls_pkg::req_type         item,
   output sls_pkg::scan_state_type  state_nxt,
   output sls_pkg::step_result_type result
);

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NUL    = 8'h00;

   localparam sls_pkg::level_type LEVEL_LIMIT = sls_pkg::level_type'(sls_pkg::DEPTH_LIMIT);
   localparam sls_pkg::level_type LEVEL_ONE   = sls_pkg::level_type'(1);

   function automatic sls_pkg::rsp_type mk_byte(input logic [7:0] b);
      sls_pkg::rsp_type r;
      r.kind     = sls_pkg::KIND_BYTE;
      r.out_byte = b;
      r.err_code = sls_pkg::ERR_NONE;
      r.last     = 1'b0;
      return r;
   endfunction

   function automatic sls_pkg::rsp_type mk_err(input sls_pkg::err_type code);
      sls_pkg::rsp_type r;
      r.kind     = sls_pkg::KIND_ERROR;
      r.out_byte = 8'h00;
      r.err_code = code;
      r.last     = 1'b0;
      return r;
   endfunction

   function automatic sls_pkg::rsp_type mk_done();
      sls_pkg::rsp_type r;
      r.kind     = sls_pkg::KIND_DONE;
      r.out_byte = 8'h00;
      r.err_code = sls_pkg::ERR_NONE;
      r.last     = 1'b0;
      return r;
   endfunction

   // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b1, 4'(c - 8'h37)};
      end
      return v;
   endfunction

   function automatic void put(input sls_pkg::rsp_type x, inout logic [1:0] n,
                               inout sls_pkg::rsp_type a, inout sls_pkg::rsp_type b);
      if (n == 2'd0) begin
         a = x;
      end else begin
         b = x;
      end
      n = n + 2'd1;
   endfunction

   always_comb begin
      sls_pkg::scan_state_type st;
      sls_pkg::rsp_type        r0;
      sls_pkg::rsp_type        r1;
      logic [1:0]              n;
      logic [4:0]              hx;
      logic                    handled;
      logic [7:0]              c;

      st      = state_cur;
      r0      = mk_done();
      r1      = mk_done();
      n       = 2'd0;
      hx      = hex_digit(item.ch);
      handled = 1'b0;
      c       = item.ch;

      if (item.at_end) begin
         put(mk_err((st.escape_phase == sls_pkg::ESC_HEX1 ||
                     st.escape_phase == sls_pkg::ESC_HEX2) ?
                    sls_pkg::ERR_HEX_SHORT : sls_pkg::ERR_UNTERM), n, r0, r1);
         st = sls_pkg::SCAN_IDLE;
      end else begin
         if (st.dollar_held) begin
            st.dollar_held = 1'b0;
            if (c == CH_QUOTE) begin
               handled = 1'b1;
               if (st.nested_level == LEVEL_LIMIT) begin
                  put(mk_err(sls_pkg::ERR_DEPTH), n, r0, r1);
                  st = sls_pkg::SCAN_IDLE;
               end else begin
                  st.nested_level = st.nested_level + LEVEL_ONE;
                  put(mk_byte(CH_DOLLAR), n, r0, r1);
                  put(mk_byte(CH_QUOTE), n, r0, r1);
               end
            end else begin
               put(mk_byte(CH_DOLLAR), n, r0, r1);
            end
         end

         if (!handled) begin
            unique case (st.escape_phase)
               sls_pkg::ESC_SLASH: begin
                  st.escape_phase = sls_pkg::ESC_NONE;
                  if (st.brace_level == '0 && st.nested_level == '0) begin
                     unique case (c)
                        CH_BSLASH: put(mk_byte(CH_BSLASH), n, r0, r1);
                        CH_N:      put(mk_byte(CH_LF), n, r0, r1);
                        CH_R:      put(mk_byte(CH_CR), n, r0, r1);
                        CH_T:      put(mk_byte(CH_TAB), n, r0, r1);
                        CH_QUOTE:  put(mk_byte(CH_QUOTE), n, r0, r1);
                        CH_ZERO:   put(mk_byte(CH_NUL), n, r0, r1);
                        CH_X:      st.escape_phase = sls_pkg::ESC_HEX1;
                        default: begin
                           put(mk_err(sls_pkg::ERR_BAD_ESC), n, r0, r1);
                           st = sls_pkg::SCAN_IDLE;
                        end
                     endcase
                  end else if (st.brace_level != '0 && c == CH_QUOTE) begin
                     if (st.nested_level != '0) begin
                        st.nested_level = st.nested_level - LEVEL_ONE;
                     end else begin
                        st.nested_level = st.nested_level + LEVEL_ONE;
                     end
                     put(mk_byte(CH_QUOTE), n, r0, r1);
                  end else begin
                     put(mk_byte(CH_BSLASH), n, r0, r1);
                     put(mk_byte(c), n, r0, r1);
                  end
               end
               sls_pkg::ESC_HEX1: begin
                  if (!hx[4]) begin
                     put(mk_err(sls_pkg::ERR_BAD_HEX), n, r0, r1);
                     st = sls_pkg::SCAN_IDLE;
                  end else begin
                     st.hex_high     = hx[3:0];
                     st.escape_phase = sls_pkg::ESC_HEX2;
                  end
               end
               sls_pkg::ESC_HEX2: begin
                  if (!hx[4]) begin
                     put(mk_err(sls_pkg::ERR_BAD_HEX), n, r0, r1);
                     st = sls_pkg::SCAN_IDLE;
                  end else begin
                     put(mk_byte({st.hex_high, hx[3:0]}), n, r0, r1);
                     st.hex_high     = 4'd0;
                     st.escape_phase = sls_pkg::ESC_NONE;
                  end
               end
               sls_pkg::ESC_NONE: begin
                  priority if (c == CH_QUOTE && st.brace_level == '0 &&
                               st.nested_level == '0) begin
                     put(mk_done(), n, r0, r1);
                     st = sls_pkg::SCAN_IDLE;
                  end else if (c == CH_BSLASH) begin
                     st.escape_phase = sls_pkg::ESC_SLASH;
                  end else if (c == CH_DOLLAR && st.brace_level != '0 &&
                               st.nested_level == '0) begin
                     st.dollar_held = 1'b1;
                  end else if (c == CH_QUOTE && st.brace_level != '0) begin
                     if (st.nested_level != '0) begin
                        st.nested_level = st.nested_level - LEVEL_ONE;
                     end else begin
                        st.nested_level = st.nested_level + LEVEL_ONE;
                     end
                     put(mk_byte(CH_QUOTE), n, r0, r1);
                  end else if (c == CH_LBRACE && st.nested_level == '0) begin
                     if (st.brace_level == LEVEL_LIMIT) begin
                        put(mk_err(sls_pkg::ERR_DEPTH), n, r0, r1);
                        st = sls_pkg::SCAN_IDLE;
                     end else begin
                        st.brace_level = st.brace_level + LEVEL_ONE;
                        put(mk_byte(c), n, r0, r1);
                     end
                  end else if (c == CH_RBRACE && st.nested_level == '0) begin
                     if (st.brace_level != '0) begin
                        st.brace_level = st.brace_level - LEVEL_ONE;
                     end
                     put(mk_byte(c), n, r0, r1);
                  end else begin
                     put(mk_byte(c), n, r0, r1);
                  end
               end
            endcase
         end
      end

      if (n == 2'd1) begin
         r0.last = 1'b1;
      end else if (n == 2'd2) begin
         r1.last = 1'b1;
      end

      state_nxt     = st;
      result.count  = n;
      result.first  = r0;
      result.second = r1;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/string_literal_scanner.sv =====
// Top level of the string literal scanner: state register and result queue.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   sls_pkg::req_type (ch, at_end)
//   rsp      out        rsp_valid/rsp_stall   sls_pkg::rsp_type (kind, out_byte,
//                                             err_code, last)
//
// An accepted byte is decoded in the cycle it arrives and its zero, one or two
// results enter a four-entry result queue; if the queue was empty, the first
// result is visible in the next cycle. One byte per cycle is sustained while
// the output keeps up. The input stalls whenever fewer than two queue entries
// are free, so bytes with two results can stall it with no output stall.
// Reset clears the scanner state and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module string_literal_scanner (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sls_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sls_pkg::rsp_type rsp_data
);

   sls_pkg::scan_state_type  scan_ff;
   sls_pkg::scan_state_type  scan_in;
   sls_pkg::step_result_type step;

   sls_pkg::rsp_type                fifo_ff [sls_pkg::FIFO_DEPTH];
   logic [sls_pkg::PTR_W-1:0]       wr_ptr_ff;
   logic [sls_pkg::PTR_W-1:0]       wr_ptr_in;
   logic [sls_pkg::PTR_W-1:0]       rd_ptr_ff;
   logic [sls_pkg::PTR_W-1:0]       rd_ptr_in;
   logic [sls_pkg::CNT_W-1:0]       count_ff;
   logic [sls_pkg::CNT_W-1:0]       count_in;
   logic [1:0]                      push_n;
   logic                            accept;
   logic                            pop;

   sls_step u_step (
      .state_cur (scan_ff),
      .item      (req_data),
      .state_nxt (scan_in),
      .result    (step)
   );

   assign req_stall = (count_ff > sls_pkg::CNT_W'(sls_pkg::FIFO_DEPTH - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign push_n    = accept ? step.count : 2'd0;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + sls_pkg::PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + sls_pkg::PTR_W'(pop);
      count_in  = count_ff + sls_pkg::CNT_W'(push_n) - sls_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff   <= sls_pkg::SCAN_IDLE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            scan_ff <= scan_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= step.first;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + sls_pkg::PTR_W'(1)] <= step.second;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sls_pkg::CNT_W'(sls_pkg::FIFO_DEPTH))
      else $error("result queue count exceeds its depth");

   a_final_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != sls_pkg::KIND_BYTE |-> rsp_data.last)
      else $error("finish or error item is not the last of its byte");

   a_end_error: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.at_end |->
         step.count == 2'd1 && step.first.kind == sls_pkg::KIND_ERROR)
      else $error("end of input did not yield exactly one error item");

   a_idle_after_close: assert property (@(posedge clock) disable iff (reset)
      accept && step.count == 2'd1 && step.first.kind != sls_pkg::KIND_BYTE
      |=> scan_ff == sls_pkg::SCAN_IDLE)
      else $error("scanner state not cleared after finish or error");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_string_literal_scanner.sv =====
// Self-checking testbench for the string literal scanner with a scoreboard and random stimulus.
`timescale 1ns / 1ps

module tb_string_literal_scanner;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 20;

   class literal_scoreboard;
      sls_pkg::level_type brace_lvl;
      sls_pkg::level_type nest_lvl;
      sls_pkg::esc_type   esc;
      logic [3:0]         hex_hi;
      bit                 dollar;
      sls_pkg::rsp_type   decoded_q[$];
      sls_pkg::rsp_type   step_q[$];
      int                 errors;

      function void clear_scan();
         brace_lvl = '0;
         nest_lvl  = '0;
         esc       = sls_pkg::ESC_NONE;
         hex_hi    = 4'd0;
         dollar    = 1'b0;
      endfunction

      function void push_rsp(sls_pkg::kind_type k, logic [7:0] b, sls_pkg::err_type e);
         sls_pkg::rsp_type r;
         r.kind     = k;
         r.out_byte = b;
         r.err_code = e;
         r.last     = 1'b0;
         step_q.push_back(r);
      endfunction

      function void abort_scan(sls_pkg::err_type e);
         push_rsp(sls_pkg::KIND_ERROR, 8'h00, e);
         clear_scan();
      endfunction

      function int hex_digit(logic [7:0] c);
         if (c >= "0" && c <= "9") return c - "0";
         if (c >= "a" && c <= "f") return c - "a" + 10;
         if (c >= "A" && c <= "F") return c - "A" + 10;
         return -1;
      endfunction

      function void toggle_nesting();
         if (nest_lvl > 0) begin
            nest_lvl--;
         end else begin
            if (nest_lvl >= sls_pkg::DEPTH_LIMIT) begin
               abort_scan(sls_pkg::ERR_DEPTH);
               return;
            end
            nest_lvl++;
         end
         push_rsp(sls_pkg::KIND_BYTE, CH_QUOTE, sls_pkg::ERR_NONE);
      endfunction

      function void plain_char(logic [7:0] c);
         if (c == CH_QUOTE && brace_lvl == 0 && nest_lvl == 0) begin
            push_rsp(sls_pkg::KIND_DONE, 8'h00, sls_pkg::ERR_NONE);
            clear_scan();
         end else if (c == CH_BSLASH) begin
            esc = sls_pkg::ESC_SLASH;
         end else if (c == CH_DOLLAR && brace_lvl > 0 && nest_lvl == 0) begin
            dollar = 1'b1;
         end else if (c == CH_QUOTE && brace_lvl > 0) begin
            toggle_nesting();
         end else if (c == CH_LBRACE && nest_lvl == 0) begin
            if (brace_lvl >= sls_pkg::DEPTH_LIMIT) begin
               abort_scan(sls_pkg::ERR_DEPTH);
            end else begin
               brace_lvl++;
               push_rsp(sls_pkg::KIND_BYTE, c, sls_pkg::ERR_NONE);
            end
         end else if (c == CH_RBRACE && nest_lvl == 0) begin
            if (brace_lvl > 0) brace_lvl--;
            push_rsp(sls_pkg::KIND_BYTE, c, sls_pkg::ERR_NONE);
         end else begin
            push_rsp(sls_pkg::KIND_BYTE, c, sls_pkg::ERR_NONE);
         end
      endfunction

      function void decode_step(sls_pkg::req_type item);
         logic [7:0] c;
         int         v;
         c = item.ch;
         if (dollar) begin
            dollar = 1'b0;
            if (c == CH_QUOTE) begin
               if (nest_lvl >= sls_pkg::DEPTH_LIMIT) begin
                  abort_scan(sls_pkg::ERR_DEPTH);
               end else begin
                  nest_lvl++;
                  push_rsp(sls_pkg::KIND_BYTE, CH_DOLLAR, sls_pkg::ERR_NONE);
                  push_rsp(sls_pkg::KIND_BYTE, CH_QUOTE, sls_pkg::ERR_NONE);
               end
               return;
            end
            push_rsp(sls_pkg::KIND_BYTE, CH_DOLLAR, sls_pkg::ERR_NONE);
         end
         case (esc)
            sls_pkg::ESC_SLASH: begin
               esc = sls_pkg::ESC_NONE;
               if (brace_lvl == 0 && nest_lvl == 0) begin
                  case (c)
                     CH_BSLASH: push_rsp(sls_pkg::KIND_BYTE, CH_BSLASH, sls_pkg::ERR_NONE);
                     "n":       push_rsp(sls_pkg::KIND_BYTE, 8'h0A, sls_pkg::ERR_NONE);
                     "r":       push_rsp(sls_pkg::KIND_BYTE, 8'h0D, sls_pkg::ERR_NONE);
                     "t":       push_rsp(sls_pkg::KIND_BYTE, 8'h09, sls_pkg::ERR_NONE);
                     CH_QUOTE:  push_rsp(sls_pkg::KIND_BYTE, CH_QUOTE, sls_pkg::ERR_NONE);
                     "0":       push_rsp(sls_pkg::KIND_BYTE, 8'h00, sls_pkg::ERR_NONE);
                     "x":       esc = sls_pkg::ESC_HEX1;
                     default:   abort_scan(sls_pkg::ERR_BAD_ESC);
                  endcase
               end else if (brace_lvl > 0 && c == CH_QUOTE) begin
                  toggle_nesting();
               end else begin
                  push_rsp(sls_pkg::KIND_BYTE, CH_BSLASH, sls_pkg::ERR_NONE);
                  push_rsp(sls_pkg::KIND_BYTE, c, sls_pkg::ERR_NONE);
               end
            end
            sls_pkg::ESC_HEX1: begin
               v = hex_digit(c);
               if (v < 0) begin
                  abort_scan(sls_pkg::ERR_BAD_HEX);
               end else begin
                  hex_hi = v[3:0];
                  esc    = sls_pkg::ESC_HEX2;
               end
            end
            sls_pkg::ESC_HEX2: begin
               v = hex_digit(c);
               if (v < 0) begin
                  abort_scan(sls_pkg::ERR_BAD_HEX);
               end else begin
                  push_rsp(sls_pkg::KIND_BYTE, {hex_hi, v[3:0]}, sls_pkg::ERR_NONE);
                  hex_hi = 4'd0;
                  esc    = sls_pkg::ESC_NONE;
               end
            end
            default: plain_char(c);
         endcase
      endfunction

      function void note_byte(sls_pkg::req_type item);
         sls_pkg::rsp_type r;
         step_q.delete();
         if (item.at_end) begin
            abort_scan((esc == sls_pkg::ESC_HEX1 || esc == sls_pkg::ESC_HEX2) ?
                       sls_pkg::ERR_HEX_SHORT : sls_pkg::ERR_UNTERM);
         end else begin
            decode_step(item);
         end
         if (step_q.size() > 0) begin
            r = step_q.pop_back();
            r.last = 1'b1;
            step_q.push_back(r);
         end
         foreach (step_q[i]) decoded_q.push_back(step_q[i]);
      endfunction

      function void check_result(sls_pkg::rsp_type got);
         sls_pkg::rsp_type want;
         if (decoded_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, %s kind=%0d byte=%h err=%0d last=%0d",
                     $time, "actual", got.kind, got.out_byte, got.err_code, got.last);
            return;
         end
         want = decoded_q.pop_front();
         if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
             got.err_code !== want.err_code || got.last !== want.last) begin
            errors++;
            $display("%0t: mismatch: expected kind=%0d byte=%h err=%0d last=%0d,",
                     $time, want.kind, want.out_byte, want.err_code, want.last);
            $display("%0t:   actual kind=%0d byte=%h err=%0d last=%0d",
                     $time, got.kind, got.out_byte, got.err_code, got.last);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sls_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sls_pkg::rsp_type rsp_data;

   literal_scoreboard sb = new();
   sls_pkg::req_type  stim_q[$];
   bit                tail = 1'b0;
   bit                calm = 1'b0;
   int                calm_left = 50;
   int                stall_left = 0;
   int unsigned       cycle_count = 0;

   string_literal_scanner u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   always @(negedge clock) begin
      if (calm_left == 0) begin
         calm      = ~calm;
         calm_left = $urandom_range(20, 120);
      end else begin
         calm_left--;
      end
      if (tail || calm) begin
         stall_left = 0;
         rsp_stall  = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_stall  = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   function automatic void add_ch(logic [7:0] c);
      sls_pkg::req_type item;
      item.ch     = c;
      item.at_end = 1'b0;
      stim_q.push_back(item);
   endfunction

   function automatic void add_end();
      sls_pkg::req_type item;
      item.ch     = 8'($urandom_range(0, 255));
      item.at_end = 1'b1;
      stim_q.push_back(item);
   endfunction

   function automatic logic [7:0] ordinary_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c == CH_QUOTE || c == CH_BSLASH || c == CH_DOLLAR ||
             c == CH_LBRACE || c == CH_RBRACE)
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic logic [7:0] hex_char();
      int         n;
      logic [7:0] c;
      n = $urandom_range(0, 21);
      if (n < 10) c = 8'(8'h30 + n);
      else if (n < 16) c = 8'(8'h61 + n - 10);
      else c = 8'(8'h41 + n - 16);
      return c;
   endfunction

   function automatic logic [7:0] escape_char();
      case ($urandom_range(0, 5))
         0: return CH_BSLASH;
         1: return "n";
         2: return "r";
         3: return "t";
         4: return CH_QUOTE;
         default: return "0";
      endcase
   endfunction

   function automatic void add_text(int count);
      repeat (count) add_ch(ordinary_char());
   endfunction

   function automatic void add_brace_group(int depth);
      add_ch(CH_LBRACE);
      repeat ($urandom_range(0, 5)) begin
         case ($urandom_range(0, 8))
            3: begin
               add_ch(CH_QUOTE);
               add_text($urandom_range(0, 3));
               if ($urandom_range(0, 1) == 1) begin
                  add_ch(CH_BSLASH);
                  add_ch($urandom_range(0, 255) == 0 ? CH_LBRACE : ordinary_char());
               end
               add_ch(CH_QUOTE);
            end
            4: begin
               add_ch(CH_DOLLAR);
               add_ch(CH_QUOTE);
               add_text($urandom_range(0, 3));
               add_ch(CH_QUOTE);
            end
            5: begin
               add_ch(CH_DOLLAR);
               add_ch(ordinary_char());
            end
            6: begin
               add_ch(CH_BSLASH);
               add_ch(ordinary_char());
            end
            7: begin
               add_ch(CH_BSLASH);
               add_ch(CH_QUOTE);
               add_text($urandom_range(0, 2));
               add_ch(CH_BSLASH);
               add_ch(CH_QUOTE);
            end
            8: begin
               if (depth < 3) add_brace_group(depth + 1);
               else add_text(1);
            end
            default: add_text(1);
         endcase
      end
      add_ch(CH_RBRACE);
   endfunction

   function automatic void add_literal();
      repeat ($urandom_range(0, 10)) begin
         case ($urandom_range(0, 9))
            4: begin
               add_ch(CH_BSLASH);
               add_ch(escape_char());
            end
            5: begin
               add_ch(CH_BSLASH);
               add_ch("x");
               add_ch(hex_char());
               add_ch(hex_char());
            end
            6, 7: add_brace_group(1);
            8: add_ch(CH_RBRACE);
            default: add_text(1);
         endcase
      end
      case ($urandom_range(0, 9))
         7: add_end();
         8: begin
            add_ch(CH_BSLASH);
            add_ch(8'($urandom_range(0, 255)));
         end
         9: begin
            add_ch(CH_BSLASH);
            add_ch("x");
            add_ch($urandom_range(0, 1) == 1 ? hex_char() : 8'($urandom_range(0, 255)));
            add_ch(8'($urandom_range(0, 255)));
         end
         default: add_ch(CH_QUOTE);
      endcase
   endfunction

   function automatic void add_noise();
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 7) == 0) add_end();
         else add_ch(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void build_stimulus();
      int base;
      add_ch(CH_QUOTE);
      add_ch(8'h00);
      add_ch(8'hFF);
      add_ch(CH_RBRACE);
      add_ch(CH_BSLASH); add_ch("n");
      add_ch(CH_BSLASH); add_ch("r");
      add_ch(CH_BSLASH); add_ch("t");
      add_ch(CH_BSLASH); add_ch(CH_BSLASH);
      add_ch(CH_BSLASH); add_ch(CH_QUOTE);
      add_ch(CH_BSLASH); add_ch("0");
      add_ch(CH_BSLASH); add_ch("x"); add_ch("a"); add_ch("F");
      add_ch(CH_BSLASH); add_ch("q");
      add_ch(CH_LBRACE); add_ch(CH_DOLLAR); add_ch(CH_QUOTE);
      add_end();
      add_ch(CH_BSLASH); add_ch("x"); add_ch("7");
      add_end();
      base = stim_q.size();
      while (stim_q.size() - base < 110) begin
         if ($urandom_range(0, 9) < 8) add_literal();
         else add_noise();
      end
      add_end();
      repeat (sls_pkg::DEPTH_LIMIT + 1) add_ch(CH_LBRACE);
      base = stim_q.size();
      while (stim_q.size() - base < 110) begin
         if ($urandom_range(0, 9) < 8) add_literal();
         else add_noise();
      end
   endfunction

   task automatic send_item(sls_pkg::req_type item);
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(item);
      @(negedge clock);
   endtask

   initial begin
      int tail_start;
      sb.clear_scan();
      build_stimulus();
      tail_start = stim_q.size() * 85 / 100;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (stim_q[i]) begin
         tail = (i >= tail_start);
         if (!tail && !calm && $urandom_range(0, 3) == 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         send_item(stim_q[i]);
      end
      req_valid = 1'b0;
      while (sb.decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
